// ===== rtl/dzps_pkg.sv =====
// Shared types and constants of the dual-zone PWM sequencer.
package dzps_pkg;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_ZONE    = 2'd1,
    MODE_DIS_RUN = 2'd2,
    MODE_DIS_END = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REQ_TICK      = 2'd0,
    REQ_DUTY_A    = 2'd1,
    REQ_DUTY_B    = 2'd2,
    REQ_DISCHARGE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_e;

  localparam logic CFG_PERIOD_A = 1'b0;
  localparam logic CFG_PERIOD_B = 1'b1;

  localparam int DUTY_W = 14;
  localparam int PER_W  = 16;
  localparam int PROD_W = DUTY_W + PER_W;

  localparam logic [15:0] DUTY_FULL    = 16'd10000;
  localparam logic [3:0]  STAGGER_LAST = 4'd11;
  localparam logic [3:0]  STAGGER_A    = 4'd1;
  localparam logic [6:0]  DIS_SWITCH   = 7'd50;
  localparam logic [6:0]  DIS_STOP     = 7'd100;
  localparam logic [6:0]  DIS_DONE     = 7'd105;

  // x / 10000 = (x >> 4) / 625; 625 reciprocal scaled by 2^36, rounded up
  localparam int          RECIP_W     = 27;
  localparam int          RECIP_SHIFT = 36;
  localparam logic [26:0] RECIP_625   = 27'd109951163;

endpackage

// ===== rtl/dual_zone_pwm_sequencer_top.sv =====
// Top level of the dual-zone PWM heater sequencer.
// One request beat is taken per clock while the output is not stalled, and each
// yields one result beat. A beat lands in an input register and its result is
// registered in the output register once the output is free to take it.
// The rate is set by the state update: the duty times period
// product of each zone is kept in a register, refreshed on duty writes and
// period writes, so a tick only runs the reciprocal multiply for the divide by
// 10000. Period writes are always accepted and apply from the next request.
module dual_zone_pwm_sequencer_top
  import dzps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] duty_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  mode_o,
  output logic [15:0] compare_a_o,
  output logic [15:0] compare_b_o,
  output logic        start_a_o,
  output logic        start_b_o,
  output logic        zone_a_on_o,
  output logic        zone_b_on_o
);

  // input stage
  logic        s1_valid_q;
  req_e        s1_req_q;
  logic [15:0] s1_duty_q;

  // state
  mode_e             mode_q, mode_d;
  logic [3:0]        stg_q, stg_d;
  logic [6:0]        dcnt_q, dcnt_d;
  logic [DUTY_W-1:0] target_q [2];
  logic [DUTY_W-1:0] target_d [2];
  logic [DUTY_W-1:0] applied_q [2];
  logic [DUTY_W-1:0] applied_d [2];
  logic [PER_W-1:0]  cmp_q [2];
  logic [PER_W-1:0]  cmp_d [2];
  logic              on_q [2];
  logic              on_d [2];
  logic [PROD_W-1:0] prod_q [2];
  logic [PROD_W-1:0] prod_d [2];
  logic [PER_W-1:0]  period_q [2];
  logic [PER_W-1:0]  quot [2];

  // output register
  logic    out_valid_q;
  status_e status_q, status_d;
  logic    sa_q, sa_d, sb_q, sb_d;

  logic fire;
  logic in_acc;
  logic cfg_acc;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign fire        = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~s1_valid_q | fire;
  assign in_acc      = in_valid_i & in_ready_o;

  dzps_div10k u_div_a (.prod_i(prod_q[0]), .quot_o(quot[0]));
  dzps_div10k u_div_b (.prod_i(prod_q[1]), .quot_o(quot[1]));

  always_comb begin
    logic zi;
    zi       = 1'b0;
    mode_d   = mode_q;
    stg_d    = stg_q;
    dcnt_d   = dcnt_q;
    status_d = ST_OK;
    sa_d     = 1'b0;
    sb_d     = 1'b0;
    for (int z = 0; z < 2; z++) begin
      target_d[z]  = target_q[z];
      applied_d[z] = applied_q[z];
      cmp_d[z]     = cmp_q[z];
      on_d[z]      = on_q[z];
      prod_d[z]    = prod_q[z];
    end
    unique case (s1_req_q)
      REQ_DUTY_A, REQ_DUTY_B: begin
        zi = (s1_req_q == REQ_DUTY_B);
        if (s1_duty_q > DUTY_FULL) begin
          status_d = ST_RANGE;
        end else begin
          target_d[zi] = s1_duty_q[DUTY_W-1:0];
          prod_d[zi]   = PROD_W'(s1_duty_q[DUTY_W-1:0]) * PROD_W'(period_q[zi]);
        end
      end
      REQ_DISCHARGE: begin
        if (mode_q == MODE_DIS_RUN || mode_q == MODE_DIS_END) begin
          status_d = ST_BUSY;
        end else begin
          mode_d = MODE_DIS_RUN;
        end
      end
      default: begin
        unique case (mode_q)
          MODE_STANDBY: begin
            stg_d = stg_q + 4'd1;
            if (stg_d == STAGGER_A) sa_d = 1'b1;
            if (stg_d == STAGGER_LAST) begin
              sb_d   = 1'b1;
              mode_d = MODE_ZONE;
              stg_d  = '0;
            end
          end
          MODE_ZONE: begin
            for (int z = 0; z < 2; z++) begin
              if (target_q[z] != applied_q[z]) begin
                applied_d[z] = target_q[z];
                on_d[z]      = (target_q[z] != '0);
                cmp_d[z]     = (target_q[z] != '0) ? quot[z] : '0;
              end
            end
          end
          MODE_DIS_RUN: begin
            if (dcnt_q == '0) begin
              cmp_d[0] = period_q[0];
              cmp_d[1] = '0;
              sa_d     = 1'b1;
              sb_d     = 1'b1;
            end
            if (dcnt_q == DIS_SWITCH) begin
              cmp_d[0] = '0;
              cmp_d[1] = period_q[1];
              sa_d     = 1'b1;
              sb_d     = 1'b1;
            end
            if (dcnt_q == DIS_STOP) begin
              cmp_d[0] = '0;
              cmp_d[1] = '0;
              sa_d     = 1'b1;
              sb_d     = 1'b1;
              mode_d   = MODE_DIS_END;
            end
            dcnt_d = dcnt_q + 7'd1;
          end
          MODE_DIS_END: begin
            dcnt_d = dcnt_q + 7'd1;
            if (dcnt_d == DIS_DONE) begin
              dcnt_d = '0;
              mode_d = MODE_STANDBY;
              for (int z = 0; z < 2; z++) begin
                on_d[z]      = 1'b0;
                applied_d[z] = '0;
                target_d[z]  = '0;
                cmp_d[z]     = '0;
                prod_d[z]    = '0;
              end
            end
          end
          default: mode_d = mode_q;
        endcase
      end
    endcase
    // a period write overrides whatever the request stage computes for that zone's product
    if (cfg_acc) begin
      zi         = cfg_index_i;
      prod_d[zi] = PROD_W'(target_q[zi]) * PROD_W'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_STANDBY;
      stg_q       <= '0;
      dcnt_q      <= '0;
      for (int z = 0; z < 2; z++) begin
        target_q[z]  <= '0;
        applied_q[z] <= '0;
        cmp_q[z]     <= '0;
        on_q[z]      <= 1'b0;
        prod_q[z]    <= '0;
        period_q[z]  <= '1;
      end
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_acc) begin
        period_q[cfg_index_i] <= cfg_data_i;
      end
      if (fire) begin
        mode_q <= mode_d;
        stg_q  <= stg_d;
        dcnt_q <= dcnt_d;
        for (int z = 0; z < 2; z++) begin
          target_q[z]  <= target_d[z];
          applied_q[z] <= applied_d[z];
          cmp_q[z]     <= cmp_d[z];
          on_q[z]      <= on_d[z];
        end
      end
      if (fire || cfg_acc) begin
        for (int z = 0; z < 2; z++) begin
          prod_q[z] <= prod_d[z];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q  <= req_e'(req_type_i);
      s1_duty_q <= duty_i;
    end
    if (fire) begin
      status_q <= status_d;
      sa_q     <= sa_d;
      sb_q     <= sb_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign mode_o      = mode_q;
  assign compare_a_o = cmp_q[0];
  assign compare_b_o = cmp_q[1];
  assign start_a_o   = sa_q;
  assign start_b_o   = sb_q;
  assign zone_a_on_o = on_q[0];
  assign zone_b_on_o = on_q[1];

  a_busy_in_discharge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BUSY |->
      mode_o == MODE_DIS_RUN || mode_o == MODE_DIS_END)
    else $error("busy status outside discharge");

  a_off_zone_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zone_a_on_o && (mode_o == MODE_STANDBY || mode_o == MODE_ZONE)
      |-> compare_a_o == '0)
    else $error("zone A off with nonzero compare");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a full pipeline");

endmodule

// ===== rtl/dzps_div10k.sv =====
// Divide a duty-period product by 10000 through a reciprocal multiply.
module dzps_div10k
  import dzps_pkg::*;
(
  input  logic [PROD_W-1:0] prod_i,
  output logic [PER_W-1:0]  quot_o
);

  localparam int XW   = PROD_W - 4;
  localparam int FULW = XW + RECIP_W;

  logic [XW-1:0]   x;
  logic [FULW-1:0] full;

  assign x      = prod_i[PROD_W-1:4];
  assign full   = FULW'(x) * FULW'(RECIP_625);
  assign quot_o = full[RECIP_SHIFT +: PER_W];

endmodule
